### hdl/zwab_pkg.sv
// Shared types and constants of the zone weighted atmosphere blend.
`timescale 1ns / 1ps
package zwab_pkg;

	localparam int POS_W   = 24;
	localparam int RAD_W   = 23;
	localparam int COL_W   = 16;
	localparam int DEN_W   = 24;
	localparam int EXP_W   = 16;
	localparam int WGT_W   = 17;
	localparam int ZC_W    = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	localparam int DIFF_W  = 25;
	localparam int SQ_W    = 50;
	localparam int ROOT_W  = 25;
	localparam int NUM_W   = 42;
	localparam int DIV_D_W = 23;
	localparam int MUL_W   = 25;
	localparam int PROD_W  = 50;

	// ceil(0.7 * 2^25); radius times this, shifted down, is at most one above 0.7 radius
	localparam int              INNER_SH  = 25;
	localparam logic [MUL_W-1:0] INNER_MUL = 25'd23488103;

	localparam logic [WGT_W-1:0] ONE_Q16   = 17'h10000;
	localparam logic [ZC_W-1:0]  NONE_CODE = 5'd16;

	localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_RED    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_GREEN  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_BLUE   = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_DENS   = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_EXP    = 8'd5;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0] cx;
		logic [POS_W-1:0] cy;
		logic [POS_W-1:0] cz;
		logic [RAD_W-1:0] rad;
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
		logic [DEN_W-1:0] dens;
		logic [EXP_W-1:0] expo;
	} zone_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_DIFF, S_SQX, S_SQY, S_SQZ, S_SQS, S_ROOT, S_CMP,
		S_INNER, S_SPAN, S_TDIV, S_T2, S_SMUL, S_SCL, S_WGT, S_BREAD, S_BM1,
		S_BM2, S_BM3, S_DONE
	} state_t;

endpackage

### hdl/zone_weighted_atmosphere_blend.sv
// Top level: zone table, query sequencer, shared multiplier and blend.
// A load word writes one zone entry and gives no result. A query word
// walks the active zones one after another through one 25x25 multiplier, a bit-serial
// square root (25 steps) and a restoring divider (42 steps, only for a zone in the
// smoothstep band); the 0.7 radius point comes from a reciprocal multiply with a one-step
// correction. The final blend waits while the output register stays full. The input is
// not ready while a query is running; a finished result waits in the output register
// and does not block the next input word. Zone table entries read as zero until loaded.
`timescale 1ns / 1ps
module zone_weighted_atmosphere_blend #(
	parameter int MAX_ZONES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// zone_index, pos_x, pos_y, pos_z, zone_radius_in, fog_red_in, fog_green_in,
	// fog_blue_in, density_in, exposure_in (lowest bit up), zero padded
	input  logic [191:0]                      s_tdata,
	// cmd
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// fog_red_out, fog_green_out, fog_blue_out, density_out, exposure_out,
	// chosen_zone, blend_weight (lowest bit up), zero padded
	output logic [111:0]                      m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [zwab_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [zwab_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import zwab_pkg::*;

	localparam int IDX_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int CNT_W = $clog2(MAX_ZONES + 1);

	// input fields
	logic [3:0]       in_idx;
	logic [POS_W-1:0] in_x, in_y, in_z;
	zone_t            in_zone;

	assign in_idx        = s_tdata[3:0];
	assign in_x          = s_tdata[27:4];
	assign in_y          = s_tdata[51:28];
	assign in_z          = s_tdata[75:52];
	assign in_zone.cx    = in_x;
	assign in_zone.cy    = in_y;
	assign in_zone.cz    = in_z;
	assign in_zone.rad   = s_tdata[98:76];
	assign in_zone.red   = s_tdata[114:99];
	assign in_zone.green = s_tdata[130:115];
	assign in_zone.blue  = s_tdata[146:131];
	assign in_zone.dens  = s_tdata[170:147];
	assign in_zone.expo  = s_tdata[186:171];

	// configuration
	logic [ZC_W-1:0]  cnt_q;
	logic [COL_W-1:0] def_red_q, def_green_q, def_blue_q;
	logic [DEN_W-1:0] def_dens_q;
	logic [EXP_W-1:0] def_exp_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			def_red_q   <= '0;
			def_green_q <= '0;
			def_blue_q  <= '0;
			def_dens_q  <= '0;
			def_exp_q   <= 16'd16384;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ZONE_COUNT: cnt_q       <= cfg_data[ZC_W-1:0];
				REG_DEF_RED:    def_red_q   <= cfg_data[COL_W-1:0];
				REG_DEF_GREEN:  def_green_q <= cfg_data[COL_W-1:0];
				REG_DEF_BLUE:   def_blue_q  <= cfg_data[COL_W-1:0];
				REG_DEF_DENS:   def_dens_q  <= cfg_data[DEN_W-1:0];
				REG_DEF_EXP:    def_exp_q   <= cfg_data[EXP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and datapath registers
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   zi_q;
	logic [CNT_W-1:0]   lim;
	logic [IDX_W-1:0]   best_q;
	logic [WGT_W-1:0]   best_w_q;
	logic [WGT_W-1:0]   w_q;
	logic [POS_W-1:0]   px_q, py_q, pz_q;
	logic [DIFF_W-1:0]  dx_q, dy_q, dz_q;
	logic [PROD_W-1:0]  p_q;
	logic [PROD_W-1:0]  acc_q;
	logic [ROOT_W-1:0]  dist_q;
	logic [RAD_W-1:0]   inner_q;
	logic [WGT_W-1:0]   t_q;
	logic [2:0]         f_q;
	logic [DEN_W-1:0]   bl_q [5];
	logic [111:0]       out_q;
	logic               m_tvalid_q;

	// unit hookups
	logic               wr_en, rd_en;
	logic [IDX_W-1:0]   rd_addr;
	zone_t              ent;
	logic               sq_start, sq_done;
	logic [SQ_W-1:0]    sq_in;
	logic [ROOT_W-1:0]  sq_root;
	logic               dv_start, dv_done;
	logic [NUM_W-1:0]   dv_num, dv_quo;
	logic [DIV_D_W-1:0] dv_den;
	logic [MUL_W-1:0]   mul_a, mul_b;

	logic               in_acc, out_load;
	logic [ROOT_W-1:0]  rad_w, inner_w;
	logic               outside, core;
	logic [ROOT_W-1:0]  excess;
	logic [RAD_W-1:0]   inner_est;
	logic [26:0]        inner_ten, rad_seven;
	logic [DEN_W-1:0]   def_sel, zone_sel;
	logic [PROD_W-1:0]  bsum;
	logic [18:0]        s_raw;
	logic [WGT_W-1:0]   s_cl;

	assign in_acc   = s_tvalid && s_tready;
	assign wr_en    = in_acc && (s_tuser[0] == CMD_LOAD) && (32'(in_idx) < MAX_ZONES);
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		if (32'(cnt_q) > MAX_ZONES) begin
			lim = CNT_W'(MAX_ZONES);
		end else begin
			lim = CNT_W'(cnt_q);
		end
	end

	function automatic logic [DIFF_W-1:0] abs_diff(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		logic signed [DIFF_W-1:0] d;
		d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

	always_comb begin
		rad_w   = ROOT_W'(ent.rad);
		inner_w = ROOT_W'(inner_q);
		outside = (dist_q >= rad_w);
		core    = (dist_q <= inner_w);
		excess  = dist_q - inner_w;
		// estimate may be one high; 10 * estimate against 7 * radius tells
		inner_est = p_q[INNER_SH+RAD_W-1:INNER_SH];
		inner_ten = 27'({inner_est, 3'b000}) + 27'({inner_est, 1'b0});
		rad_seven = 27'({ent.rad, 3'b000}) - 27'(ent.rad);
		s_raw   = p_q[34:16];
		s_cl    = (s_raw > 19'(ONE_Q16)) ? ONE_Q16 : s_raw[WGT_W-1:0];
		bsum    = acc_q + p_q;
		case (f_q)
			3'd0:    begin def_sel = DEN_W'(def_red_q);   zone_sel = DEN_W'(ent.red);   end
			3'd1:    begin def_sel = DEN_W'(def_green_q); zone_sel = DEN_W'(ent.green); end
			3'd2:    begin def_sel = DEN_W'(def_blue_q);  zone_sel = DEN_W'(ent.blue);  end
			3'd3:    begin def_sel = def_dens_q;          zone_sel = ent.dens;          end
			3'd4:    begin def_sel = DEN_W'(def_exp_q);   zone_sel = DEN_W'(ent.expo);  end
			default: begin def_sel = '0;                  zone_sel = '0;                end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (s_tvalid && s_tuser[0] == CMD_QUERY) state_d = S_CHECK;
			S_CHECK: state_d = (zi_q >= lim) ? S_BREAD : S_DIFF;
			S_DIFF:  state_d = S_SQX;
			S_SQX:   state_d = S_SQY;
			S_SQY:   state_d = S_SQZ;
			S_SQZ:   state_d = S_SQS;
			S_SQS:   state_d = S_ROOT;
			S_ROOT:  if (sq_done) state_d = S_CMP;
			S_CMP:   state_d = outside ? S_WGT : S_INNER;
			S_INNER: state_d = S_SPAN;
			S_SPAN:  state_d = core ? S_WGT : S_TDIV;
			S_TDIV:  if (dv_done) state_d = S_T2;
			S_T2:    state_d = S_SMUL;
			S_SMUL:  state_d = S_SCL;
			S_SCL:   state_d = S_WGT;
			S_WGT:   state_d = S_CHECK;
			S_BREAD: state_d = S_BM1;
			S_BM1:   state_d = S_BM2;
			S_BM2:   state_d = S_BM3;
			S_BM3:   state_d = (f_q == 3'd4) ? S_DONE : S_BM1;
			S_DONE:  if (!m_tvalid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = best_q;
		sq_start = 1'b0;
		sq_in    = bsum;
		dv_start = 1'b0;
		dv_num   = '0;
		dv_den   = '0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			S_IDLE:  s_tready = 1'b1;
			S_CHECK: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(zi_q);
			end
			S_SQX:   begin mul_a = dx_q; mul_b = dx_q; end
			S_SQY:   begin mul_a = dy_q; mul_b = dy_q; end
			S_SQZ:   begin mul_a = dz_q; mul_b = dz_q; end
			S_SQS:   sq_start = 1'b1;
			S_CMP:   begin mul_a = MUL_W'(ent.rad); mul_b = INNER_MUL; end
			S_SPAN:  begin
				dv_start = !core;
				dv_num   = NUM_W'({excess[RAD_W-1:0], 16'h0000});
				dv_den   = ent.rad - inner_q;
			end
			S_T2:    begin mul_a = MUL_W'(t_q); mul_b = MUL_W'(t_q); end
			S_SMUL:  begin
				mul_a = MUL_W'(p_q[32:16]);
				mul_b = MUL_W'(18'd196608 - {t_q, 1'b0});
			end
			S_BREAD: rd_en = 1'b1;
			S_BM1:   begin mul_a = MUL_W'(def_sel); mul_b = MUL_W'(ONE_Q16 - best_w_q); end
			S_BM2:   begin mul_a = MUL_W'(zone_sel); mul_b = MUL_W'(best_w_q); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// shared multiplier, registered product
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q     <= in_x;
				py_q     <= in_y;
				pz_q     <= in_z;
				zi_q     <= '0;
				best_q   <= '0;
				best_w_q <= '0;
				f_q      <= '0;
			end
			S_DIFF: begin
				dx_q <= abs_diff(px_q, ent.cx);
				dy_q <= abs_diff(py_q, ent.cy);
				dz_q <= abs_diff(pz_q, ent.cz);
			end
			S_SQY:   acc_q <= p_q;
			S_SQZ:   acc_q <= bsum;
			S_ROOT:  if (sq_done) dist_q <= sq_root;
			S_CMP:   w_q <= '0;
			S_INNER: inner_q <= (inner_ten > rad_seven) ? inner_est - 1'b1 : inner_est;
			S_SPAN:  w_q <= ONE_Q16;
			S_TDIV:  if (dv_done) t_q <= (dv_quo > NUM_W'(ONE_Q16)) ? ONE_Q16 : dv_quo[WGT_W-1:0];
			S_SCL:   w_q <= ONE_Q16 - s_cl;
			S_WGT: begin
				// strict compare keeps the lowest index on ties
				if (w_q > best_w_q) begin
					best_w_q <= w_q;
					best_q   <= IDX_W'(zi_q);
				end
				zi_q <= zi_q + 1'b1;
			end
			S_BM2:   acc_q <= p_q;
			S_BM3: begin
				bl_q[f_q] <= bsum[39:16];
				f_q       <= f_q + 1'b1;
			end
			default: ;
		endcase
		if (out_load) begin
			out_q <= {2'b00,
				best_w_q,
				(best_w_q != '0) ? ZC_W'(best_q) : NONE_CODE,
				bl_q[4][EXP_W-1:0],
				bl_q[3],
				bl_q[2][COL_W-1:0],
				bl_q[1][COL_W-1:0],
				bl_q[0][COL_W-1:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	zwab_table #(
		.DEPTH(MAX_ZONES),
		.IDX_W(IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (IDX_W'(in_idx)),
		.wr_data (in_zone),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ent)
	);

	zwab_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.done     (sq_done),
		.root     (sq_root)
	);

	zwab_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && s_tvalid && s_tuser[0] == CMD_QUERY) |=> (state_q == S_CHECK))
		else $error("query accept did not start the zone walk");

	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BM1) |-> (best_w_q <= ONE_Q16))
		else $error("best weight above one");

	a_wgt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WGT) |-> (w_q <= ONE_Q16))
		else $error("zone weight above one");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT || state_q == S_INNER || state_q == S_TDIV) |-> !s_tready)
		else $error("input ready while a unit is busy");

endmodule

### hdl/zwab_table.sv
// Zone table memory with per-entry valid bits, one write and one registered read port.
`timescale 1ns / 1ps
module zwab_table #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  zwab_pkg::zone_t    wr_data,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output zwab_pkg::zone_t    rd_data
);
	import zwab_pkg::*;

	zone_t            mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	zone_t            rd_q;
	logic             rv_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rv_q <= valid_q[rd_addr];
			end
		end
	end

	// never-loaded entries read as zero
	assign rd_data = rv_q ? rd_q : '0;

endmodule

### hdl/zwab_sqrt.sv
// Bit-serial floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module zwab_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [zwab_pkg::SQ_W-1:0] radicand,
	output logic                      done,
	output logic [zwab_pkg::ROOT_W-1:0] root
);
	import zwab_pkg::*;

	localparam int CW  = $clog2(ROOT_W);
	localparam int RMW = ROOT_W + 3;

	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [SQ_W-1:0]   x_q;
	logic [ROOT_W-1:0] root_q;
	logic [RMW-1:0]    rem_q;

	logic [RMW-1:0]    rn;
	logic [RMW-1:0]    trial;
	logic              ge;

	always_comb begin
		rn    = {rem_q[RMW-3:0], x_q[SQ_W-1:SQ_W-2]};
		trial = {1'b0, root_q, 2'b01};
		ge    = (rn >= trial);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (run_q) begin
			x_q    <= {x_q[SQ_W-3:0], 2'b00};
			rem_q  <= ge ? (rn - trial) : rn;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(ROOT_W - 1));
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ROOT_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### hdl/zwab_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module zwab_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [zwab_pkg::NUM_W-1:0]   num,
	input  logic [zwab_pkg::DIV_D_W-1:0] den,
	output logic                         done,
	output logic [zwab_pkg::NUM_W-1:0]   quo
);
	import zwab_pkg::*;

	localparam int CW = $clog2(NUM_W);

	logic [CW-1:0]      cnt_q;
	logic               run_q;
	logic               done_q;
	logic [NUM_W-1:0]   quo_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;

	logic [DIV_D_W:0]   r;
	logic [DIV_D_W:0]   rs;
	logic               ge;

	always_comb begin
		r  = {rem_q, quo_q[NUM_W-1]};
		ge = (r >= {1'b0, den_q});
		rs = r - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? rs[DIV_D_W-1:0] : r[DIV_D_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(NUM_W - 1));
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUM_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
